/* rtl/gpsp_pkg.sv */
`timescale 1ns / 1ps
package gpsp_pkg;

  // frame geometry
  localparam int FRAME_BYTES = 9;
  localparam int BYTE_CNT_W  = 5;
  localparam int STORE_BYTES = 8;

  // protocol bytes
  localparam logic [7:0] CMD_BYTE_START = 8'h01;
  localparam logic [7:0] CMD_BYTE_POLL  = 8'h42;
  localparam logic [7:0] CMD_BYTE_IDLE  = 8'h00;
  localparam logic [7:0] ACK_BYTE       = 8'h5a;
  localparam logic [7:0] AXIS_CENTER    = 8'h80;

  // L3 and R3 sit in bits 1 and 2 of the button word
  localparam logic [15:0] STICK_BTN_MASK = 16'h0006;

  // input opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_BIT   = 1'b1;

  // config register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DIGITAL_ID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RED_ID     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_ID   = 2'd2;

  localparam logic [7:0] DIGITAL_ID_RST = 8'h41;
  localparam logic [7:0] RED_ID_RST     = 8'h73;
  localparam logic [7:0] GREEN_ID_RST   = 8'h53;

  typedef struct packed {
    logic op;
    logic data_bit;
  } in_item_t;

  typedef struct packed {
    logic        cmd_bit;
    logic        frame_done;
    logic [7:0]  pad_id;
    logic        decoded_valid;
    logic [15:0] buttons;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
  } out_item_t;

  typedef struct packed {
    logic [7:0] digital_id;
    logic [7:0] red_id;
    logic [7:0] green_id;
  } cfg_regs_t;

  // bytes[k] holds frame byte k+1
  typedef struct packed {
    logic                        done;
    logic [STORE_BYTES-1:0][7:0] bytes;
  } frame_evt_t;

  function automatic logic [7:0] cmd_byte(input logic [BYTE_CNT_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      BYTE_CNT_W'(0): b = CMD_BYTE_START;
      BYTE_CNT_W'(1): b = CMD_BYTE_POLL;
      default:        b = CMD_BYTE_IDLE;
    endcase
    return b;
  endfunction

endpackage

/* rtl/gpsp_frame.sv */
`timescale 1ns / 1ps
module gpsp_frame (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  gpsp_pkg::in_item_t  item,
  output logic                cmd_bit,
  output gpsp_pkg::frame_evt_t evt
);
  import gpsp_pkg::*;

  logic                        in_frame_r, in_frame_nxt;
  logic [2:0]                  bit_cnt_r, bit_cnt_nxt;
  logic [BYTE_CNT_W-1:0]       byte_cnt_r, byte_cnt_nxt;
  logic [7:0]                  shift_r, shift_nxt;
  logic [STORE_BYTES-1:0][7:0] store_r, store_nxt;
  logic [7:0]                  shift_in;
  logic                        byte_end;
  logic                        done;
  logic [7:0]                  cmd_nxt;

  assign shift_in = {item.data_bit, shift_r[7:1]};
  assign byte_end = (bit_cnt_r == 3'd7);

  // frame counters and shifter
  always_comb begin
    in_frame_nxt = in_frame_r;
    bit_cnt_nxt  = bit_cnt_r;
    byte_cnt_nxt = byte_cnt_r;
    shift_nxt    = shift_r;
    store_nxt    = store_r;
    done         = 1'b0;
    if (item.op == OP_START) begin
      in_frame_nxt = 1'b1;
      bit_cnt_nxt  = 3'd0;
      byte_cnt_nxt = '0;
      shift_nxt    = 8'h00;
    end else if (in_frame_r) begin
      shift_nxt   = shift_in;
      bit_cnt_nxt = bit_cnt_r + 3'd1;
      if (byte_end) begin
        for (int k = 0; k < STORE_BYTES; k++) begin
          if (byte_cnt_r == BYTE_CNT_W'(k + 1)) begin
            store_nxt[k] = shift_in;
          end
        end
        shift_nxt    = 8'h00;
        byte_cnt_nxt = byte_cnt_r + BYTE_CNT_W'(1);
        if (byte_cnt_r == BYTE_CNT_W'(FRAME_BYTES - 1)) begin
          in_frame_nxt = 1'b0;
          byte_cnt_nxt = '0;
          done         = 1'b1;
        end
      end
    end
  end

  // command level for the next bit slot
  assign cmd_nxt = cmd_byte(byte_cnt_nxt);
  assign cmd_bit = in_frame_nxt ? cmd_nxt[bit_cnt_nxt] : 1'b1;

  // decode sees the byte store including the byte that just closed
  assign evt.done  = done;
  assign evt.bytes = store_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      bit_cnt_r  <= 3'd0;
      byte_cnt_r <= '0;
      shift_r    <= 8'h00;
    end else if (step) begin
      in_frame_r <= in_frame_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      shift_r    <= shift_nxt;
    end
  end

  // received bytes, no reset: read only after written in the same frame
  always_ff @(posedge clk) begin
    if (step) begin
      store_r <= store_nxt;
    end
  end

endmodule

/* rtl/gpsp_decode.sv */
`timescale 1ns / 1ps
module gpsp_decode (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  gpsp_pkg::frame_evt_t evt,
  input  gpsp_pkg::cfg_regs_t  cfg,
  output logic [7:0]           pad_id,
  output logic                 decoded_valid,
  output logic [15:0]          buttons,
  output logic [3:0][7:0]      axes
);
  import gpsp_pkg::*;

  logic [7:0]      last_id_r, last_id_nxt;
  logic            last_valid_r, last_valid_nxt;
  logic [15:0]     buttons_r, buttons_nxt;
  logic [3:0][7:0] axes_r, axes_nxt;
  logic [7:0]      id;
  logic            is_red, is_green, known, good;
  logic [15:0]     fresh, keep;

  assign id       = evt.bytes[0];
  assign is_red   = (id == cfg.red_id);
  assign is_green = (id == cfg.green_id);
  assign known    = (id == cfg.digital_id) || is_red || is_green;
  assign good     = known && (evt.bytes[1] == ACK_BYTE);
  assign fresh    = ~{evt.bytes[3], evt.bytes[2]};
  assign keep     = is_red ? 16'h0000 : STICK_BTN_MASK;

  // frame decode on the closing bit
  always_comb begin
    last_id_nxt    = last_id_r;
    last_valid_nxt = last_valid_r;
    buttons_nxt    = buttons_r;
    axes_nxt       = axes_r;
    if (evt.done) begin
      last_id_nxt    = id;
      last_valid_nxt = good;
      if (good) begin
        buttons_nxt = (buttons_r & keep) | (fresh & ~keep);
        if (is_red || is_green) begin
          axes_nxt = {evt.bytes[7], evt.bytes[6], evt.bytes[5], evt.bytes[4]};
        end else begin
          axes_nxt = {4{AXIS_CENTER}};
        end
      end
    end
  end

  assign pad_id        = last_id_nxt;
  assign decoded_valid = last_valid_nxt;
  assign buttons       = buttons_nxt;
  assign axes          = axes_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_id_r    <= 8'h00;
      last_valid_r <= 1'b0;
      buttons_r    <= 16'h0000;
      axes_r       <= {4{AXIS_CENTER}};
    end else if (step) begin
      last_id_r    <= last_id_nxt;
      last_valid_r <= last_valid_nxt;
      buttons_r    <= buttons_nxt;
      axes_r       <= axes_nxt;
    end
  end

endmodule

/* rtl/game_pad_serial_poller.sv */
`timescale 1ns / 1ps
// Host side of a game pad poll frame.
// Input channel (in_valid/in_ready/in_item): op 0 opens a frame, op 1 hands
// in one sampled data bit, LSB first. Every accepted item gives exactly one
// result item on the output channel (out_valid/out_ready/out_item): the
// command level for the next bit slot, a frame done flag and the held pad
// state (id, valid, buttons, four axes), updated when a frame closes.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 digital
// id, 1 analog red id, 2 analog green id; always ready, other indexes drop.
// Path: an accepted item passes the input register, then the result
// register. Throughput: one item per cycle while the output is not stalled;
// the whole bit step is one pass of logic between the two registers.
// Reset (rst_n low, synchronous): no frame open, buttons 0, axes 0x80,
// pad id 0, ids back to 0x41, 0x73, 0x53.
// Stall: while out_ready is low the result holds; the input register takes
// one more item, then in_ready drops until the result is taken.
module game_pad_serial_poller (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  gpsp_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output gpsp_pkg::out_item_t                 out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gpsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [7:0]                          cfg_data
);
  import gpsp_pkg::*;

  logic       in_valid_r;
  in_item_t   in_item_r;
  logic       out_valid_r;
  out_item_t  out_item_r, out_item_nxt;
  cfg_regs_t  cfg_r;
  logic       advance;
  logic       cmd_bit;
  frame_evt_t evt;
  logic [7:0] pad_id;
  logic       decoded_valid;
  logic [15:0] buttons;
  logic [3:0][7:0] axes;

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.digital_id <= DIGITAL_ID_RST;
      cfg_r.red_id     <= RED_ID_RST;
      cfg_r.green_id   <= GREEN_ID_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DIGITAL_ID: cfg_r.digital_id <= cfg_data;
        REG_RED_ID:     cfg_r.red_id     <= cfg_data;
        REG_GREEN_ID:   cfg_r.green_id   <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
  end

  gpsp_frame u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .item    (in_item_r),
    .cmd_bit (cmd_bit),
    .evt     (evt)
  );

  gpsp_decode u_decode (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance),
    .evt           (evt),
    .cfg           (cfg_r),
    .pad_id        (pad_id),
    .decoded_valid (decoded_valid),
    .buttons       (buttons),
    .axes          (axes)
  );

  // result assembly
  always_comb begin
    out_item_nxt.cmd_bit       = cmd_bit;
    out_item_nxt.frame_done    = evt.done;
    out_item_nxt.pad_id        = pad_id;
    out_item_nxt.decoded_valid = decoded_valid;
    out_item_nxt.buttons       = buttons;
    out_item_nxt.right_x       = axes[0];
    out_item_nxt.right_y       = axes[1];
    out_item_nxt.left_x        = axes[2];
    out_item_nxt.left_y        = axes[3];
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule

/* rtl/gpsp_checker.sv */
`timescale 1ns / 1ps
module gpsp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input gpsp_pkg::out_item_t            out_item
);
  import gpsp_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // a closed frame leaves the command line idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.frame_done |-> out_item.cmd_bit)
    else $error("command line not idle after frame end");

  // a fresh result comes from an item taken earlier through the input register
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching item");

  // a free output never blocks the input
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output free");

endmodule

bind game_pad_serial_poller gpsp_checker u_gpsp_checker (.*);

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import gpsp_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_PRINTED    = 40;
  localparam int BITS_PER_FRAME = 8 * FRAME_BYTES;

  typedef enum int {
    KIND_RED,
    KIND_GREEN,
    KIND_DIGITAL,
    KIND_UNKNOWN_ID,
    KIND_BAD_ACK
  } frame_kind_e;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_item   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data  = '0;

  game_pad_serial_poller uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // poller shadow state, as left by reset
  cfg_regs_t   known_ids   = {DIGITAL_ID_RST, RED_ID_RST, GREEN_ID_RST};
  logic        frame_open  = 1'b0;
  logic [2:0]  bit_pos     = '0;
  logic [4:0]  byte_pos    = '0;
  logic [7:0]  shift_acc   = '0;
  logic [7:0]  rx_bytes [32] = '{default: 8'h00};
  logic [15:0] button_word = '0;
  logic [7:0]  axis_val [4] = '{default: AXIS_CENTER};
  logic [7:0]  held_id     = '0;
  logic        held_valid  = 1'b0;

  in_item_t  poll_items_q [$];
  out_item_t pad_reports_due [$];

  int error_count  = 0;
  int result_index = 0;
  int stall_cycles = 0;
  int burst_left   = 1;
  int gap_left     = 0;
  int ready_mode   = 0;
  int mode_left    = 0;
  int ready_tick   = 0;
  out_item_t want_report;

  // one bit step of the poller: returns the pad report the block should give
  function automatic out_item_t compute_pad_report(input in_item_t it);
    out_item_t   rep;
    logic        done;
    logic        is_red;
    logic        is_green;
    logic        known;
    logic [15:0] fresh;
    logic [15:0] keep;
    logic [7:0]  cmd;
    done = 1'b0;
    if (it.op == OP_START) begin
      // a start always opens a fresh frame, dropping any open one
      frame_open = 1'b1;
      bit_pos    = '0;
      byte_pos   = '0;
      shift_acc  = '0;
    end else if (frame_open) begin
      shift_acc = {it.data_bit, shift_acc[7:1]};
      bit_pos   = bit_pos + 3'd1;
      if (bit_pos == 3'd0) begin
        rx_bytes[byte_pos] = shift_acc;
        shift_acc = '0;
        byte_pos  = byte_pos + 5'd1;
        if (byte_pos == FRAME_BYTES) begin
          frame_open = 1'b0;
          byte_pos   = '0;
          done       = 1'b1;
          // id and acknowledge check
          is_red     = (rx_bytes[1] == known_ids.red_id);
          is_green   = (rx_bytes[1] == known_ids.green_id);
          known      = (rx_bytes[1] == known_ids.digital_id) || is_red || is_green;
          held_id    = rx_bytes[1];
          held_valid = known && (rx_bytes[2] == ACK_BYTE);
          if (held_valid) begin
            // stick buttons only move for the red id
            fresh       = ~{rx_bytes[4], rx_bytes[3]};
            keep        = is_red ? 16'h0000 : STICK_BTN_MASK;
            button_word = (button_word & keep) | (fresh & ~keep);
            if (is_red || is_green) begin
              for (int k = 0; k < 4; k++) axis_val[k] = rx_bytes[5 + k];
            end else begin
              for (int k = 0; k < 4; k++) axis_val[k] = AXIS_CENTER;
            end
          end
        end
      end
    end
    // command level for the next bit slot, idle high outside a frame
    case (byte_pos)
      5'd0:    cmd = CMD_BYTE_START;
      5'd1:    cmd = CMD_BYTE_POLL;
      default: cmd = CMD_BYTE_IDLE;
    endcase
    rep.cmd_bit       = frame_open ? cmd[bit_pos] : 1'b1;
    rep.frame_done    = done;
    rep.pad_id        = held_id;
    rep.decoded_valid = held_valid;
    rep.buttons       = button_word;
    rep.right_x       = axis_val[0];
    rep.right_y       = axis_val[1];
    rep.left_x        = axis_val[2];
    rep.left_y        = axis_val[3];
    return rep;
  endfunction

  task automatic report_error(input string msg);
    if (error_count < MAX_PRINTED) $display("ERROR: %s", msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_error($sformatf("result %0d %s: got %h, expected %h",
                             result_index, name, got, want));
  endtask

  // sender: bursts of items with random gaps between them
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) pad_reports_due.push_back(compute_pad_report(in_item));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (poll_items_q.size() > 0) begin
          in_item  <= poll_items_q.pop_front();
          in_valid <= 1'b1;
          burst_left = burst_left - 1;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each result item, stall in changing modes
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pad_reports_due.size() == 0) begin
          report_error($sformatf("result %0d arrived with none expected", result_index));
        end else begin
          want_report = pad_reports_due.pop_front();
          check_field("cmd_bit", out_item.cmd_bit, want_report.cmd_bit);
          check_field("frame_done", out_item.frame_done, want_report.frame_done);
          check_field("pad_id", out_item.pad_id, want_report.pad_id);
          check_field("decoded_valid", out_item.decoded_valid, want_report.decoded_valid);
          check_field("buttons", out_item.buttons, want_report.buttons);
          check_field("right_x", out_item.right_x, want_report.right_x);
          check_field("right_y", out_item.right_y, want_report.right_y);
          check_field("left_x", out_item.left_x, want_report.left_x);
          check_field("left_y", out_item.left_y, want_report.left_y);
        end
        result_index++;
      end
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(20, 300);
      end else begin
        mode_left = mode_left - 1;
      end
      ready_tick++;
      case (ready_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= (ready_tick % 4 == 0);
      endcase
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_poll_item(input logic op, input logic data_bit);
    in_item_t it;
    it.op       = op;
    it.data_bit = data_bit;
    poll_items_q.push_back(it);
  endtask

  // one pad byte, LSB first
  task automatic push_byte(input logic [7:0] b);
    for (int k = 0; k < 8; k++) push_poll_item(OP_BIT, b[k]);
  endtask

  // byte values with the extremes weighted up
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 4))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // a whole well-formed frame with random content
  task automatic push_frame(input frame_kind_e kind);
    logic [7:0] id;
    logic [7:0] ack;
    ack = ACK_BYTE;
    case (kind)
      KIND_RED:     id = known_ids.red_id;
      KIND_GREEN:   id = known_ids.green_id;
      KIND_DIGITAL: id = known_ids.digital_id;
      KIND_UNKNOWN_ID: begin
        do begin
          id = 8'($urandom_range(0, 255));
        end while (id == known_ids.digital_id || id == known_ids.red_id ||
                   id == known_ids.green_id);
      end
      default: begin
        id = $urandom_range(0, 1) ? known_ids.red_id : known_ids.digital_id;
        do begin
          ack = pick_byte();
        end while (ack == ACK_BYTE);
      end
    endcase
    push_poll_item(OP_START, 1'($urandom_range(0, 1)));
    push_byte(pick_byte());
    push_byte(id);
    push_byte(ack);
    for (int k = 3; k < FRAME_BYTES; k++) push_byte(pick_byte());
  endtask

  // block idle: nothing queued, nothing presented, nothing outstanding
  task automatic wait_idle();
    while (poll_items_q.size() != 0 || in_valid || pad_reports_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_id_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DIGITAL_ID: known_ids.digital_id = val;
      REG_RED_ID:     known_ids.red_id     = val;
      REG_GREEN_ID:   known_ids.green_id   = val;
      default: ;
    endcase
  endtask

  task automatic set_pad_ids(input logic [7:0] dig, input logic [7:0] red,
                             input logic [7:0] green);
    write_id_reg(REG_DIGITAL_ID, dig);
    write_id_reg(REG_RED_ID, red);
    write_id_reg(REG_GREEN_ID, green);
  endtask

  // mostly full frames, some cut short by a restart, some stray bits
  task automatic run_random_phase(input int budget);
    int used;
    int frames;
    int pick;
    int n;
    used   = 0;
    frames = 0;
    @(negedge clk);
    while (used < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        push_frame(frames < 5 ? frame_kind_e'(frames) : frame_kind_e'($urandom_range(0, 4)));
        frames++;
        used += 1 + BITS_PER_FRAME;
      end else if (pick < 88) begin
        n = $urandom_range(1, BITS_PER_FRAME - 1);
        push_poll_item(OP_START, 1'($urandom_range(0, 1)));
        repeat (n) push_poll_item(OP_BIT, 1'($urandom_range(0, 1)));
        used += 1 + n;
      end else begin
        repeat ($urandom_range(1, 4)) push_poll_item(OP_BIT, 1'($urandom_range(0, 1)));
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // stray bits with no frame open, then a frame restarted midway
    @(negedge clk);
    push_poll_item(OP_BIT, 1'b0);
    push_poll_item(OP_BIT, 1'b1);
    push_poll_item(OP_START, 1'b0);
    push_poll_item(OP_BIT, 1'b1);
    push_poll_item(OP_BIT, 1'b0);
    push_poll_item(OP_BIT, 1'b1);
    push_poll_item(OP_BIT, 1'b1);
    push_poll_item(OP_BIT, 1'b0);
    push_poll_item(OP_START, 1'b1);
    push_byte(8'hff);
    push_poll_item(OP_BIT, 1'b0);
    wait_idle();

    // id settings: reset values, the extremes, one id for all, random, reset again
    run_random_phase(200);
    set_pad_ids(8'h00, 8'hff, 8'h80);
    run_random_phase(200);
    set_pad_ids(8'hff, 8'h00, 8'hff);
    run_random_phase(200);
    set_pad_ids(8'h00, 8'h00, 8'h00);
    run_random_phase(200);
    set_pad_ids(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
    run_random_phase(200);
    set_pad_ids(DIGITAL_ID_RST, RED_ID_RST, GREEN_ID_RST);
    run_random_phase(200);

    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/gpsp_pkg.sv
rtl/gpsp_frame.sv
rtl/gpsp_decode.sv
rtl/game_pad_serial_poller.sv
rtl/gpsp_checker.sv
tb/sv/tb_top.sv
